@@ rtl/core/mss_pkg.sv @@
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and constants for the motor soft-start controller.
// ----------------------------------------------------------------------------
package mss_pkg;

  // request function codes
  typedef enum logic [1:0] {
    FUNC_TICK       = 2'd0,
    FUNC_SET_TARGET = 2'd1,
    FUNC_CLEAR      = 2'd2,
    FUNC_ESTOP      = 2'd3
  } func_e;

  // lockout cause
  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_UV   = 2'd1,
    FAULT_OC   = 2'd2
  } fault_e;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_CURRENT = 2'd0;
  localparam logic [1:0] CFG_MIN_VOLTAGE = 2'd1;
  localparam logic [1:0] CFG_SAG_PERCENT = 2'd2;
  localparam logic [1:0] CFG_RAMP_RATE   = 2'd3;

  // configuration reset values
  localparam logic [15:0] MAX_CURRENT_RST = 16'd5000;
  localparam logic [15:0] MIN_VOLTAGE_RST = 16'd9000;
  localparam logic [6:0]  SAG_PERCENT_RST = 7'd20;
  localparam logic [12:0] RAMP_RATE_RST   = 13'd512;

  // configuration limits
  localparam logic [6:0]  SAG_PERCENT_MAX = 7'd100;
  localparam logic [12:0] RAMP_RATE_MIN   = 13'd26;
  localparam logic [12:0] RAMP_RATE_MAX   = 13'd5120;

  // supply thresholds in millivolts
  localparam logic [15:0] SUPPLY_VALID_MV = 16'd5000;
  localparam logic [15:0] UV_FLOOR_MV     = 16'd1000;
  localparam logic [15:0] IDLE_DEFAULT_MV = 16'd12000;

  // over-current debounce
  localparam logic [1:0] OC_COUNT_MAX  = 2'd3;
  localparam logic [1:0] OC_TRIP_COUNT = 2'd3;

  // sag ceiling when released
  localparam logic [7:0] CEIL_FULL = 8'hFF;

  // clamped configuration as seen by the datapath
  typedef struct packed {
    logic [15:0] max_current_ma;
    logic [15:0] min_voltage_mv;
    logic [6:0]  sag_percent;
    logic [12:0] ramp_rate;
  } cfg_t;

  // one request
  typedef struct packed {
    func_e       func;
    logic [15:0] current_ma;
    logic [15:0] supply_mv;
    logic [15:0] idle_mv;
    logic [7:0]  target_duty;
  } item_t;

  // one result
  typedef struct packed {
    logic [7:0] duty;
    logic       locked;
    fault_e     fault;
    logic [7:0] sag_limit;
  } result_t;

endpackage

@@ rtl/core/mss_cfg.sv @@
// ----------------------------------------------------------------------------
// mss_cfg
// Configuration registers; sag percent and ramp rate are range-limited as written.
// ----------------------------------------------------------------------------
module mss_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  output mss_pkg::cfg_t      cfg_o
);
  import mss_pkg::*;

  cfg_t       cfg_q;
  logic [6:0]  pct_raw;
  logic [12:0] rate_raw;
  logic [6:0]  pct_lim;
  logic [12:0] rate_lim;

  // clamp incoming values
  assign pct_raw  = cfg_wdata_i[6:0];
  assign rate_raw = cfg_wdata_i[12:0];
  assign pct_lim  = (pct_raw > SAG_PERCENT_MAX) ? SAG_PERCENT_MAX : pct_raw;
  assign rate_lim = (rate_raw < RAMP_RATE_MIN) ? RAMP_RATE_MIN :
                    (rate_raw > RAMP_RATE_MAX) ? RAMP_RATE_MAX : rate_raw;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_current_ma <= MAX_CURRENT_RST;
      cfg_q.min_voltage_mv <= MIN_VOLTAGE_RST;
      cfg_q.sag_percent    <= SAG_PERCENT_RST;
      cfg_q.ramp_rate      <= RAMP_RATE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_CURRENT: cfg_q.max_current_ma <= cfg_wdata_i;
        CFG_MIN_VOLTAGE: cfg_q.min_voltage_mv <= cfg_wdata_i;
        CFG_SAG_PERCENT: cfg_q.sag_percent    <= pct_lim;
        CFG_RAMP_RATE:   cfg_q.ramp_rate      <= rate_lim;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/mss_in_reg.sv @@
// ----------------------------------------------------------------------------
// mss_in_reg
// Input register: captures one request and holds it until the core takes it.
// ----------------------------------------------------------------------------
module mss_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  mss_pkg::item_t  item_i,
  input  logic            take_i,
  output logic            valid_o,
  output mss_pkg::item_t  item_o
);
  import mss_pkg::*;

  logic  valid_q;
  logic  valid_d;
  item_t item_q;
  logic  load;

  // full and not drained this cycle
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/core/mss_core.sv @@
// ----------------------------------------------------------------------------
// mss_core
// Controller state and its combinational per-request update.
// ----------------------------------------------------------------------------
module mss_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  mss_pkg::item_t    item_i,
  input  mss_pkg::cfg_t     cfg_i,
  output mss_pkg::result_t  res_o
);
  import mss_pkg::*;

  // state
  logic [7:0]  target_q, target_d;
  logic [15:0] duty_q, duty_d;
  logic [7:0]  ceil_q, ceil_d;
  logic [15:0] snap_q, snap_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        lock_q, lock_d;
  fault_e      fault_q, fault_d;

  // tick datapath
  logic [15:0] snap_live;
  logic [15:0] snap_tick;
  logic        uv_hit;
  logic        oc_hit;
  logic [1:0]  cnt_tick;
  logic        oc_trip;
  logic [22:0] sag_lhs;
  logic [22:0] sag_rhs;
  logic        sag_hit;
  logic [7:0]  ceil_tick;
  logic [7:0]  eff;
  logic [15:0] goal;
  logic [13:0] rate_dn;
  logic [15:0] gap_up;
  logic [15:0] gap_dn;
  logic [15:0] duty_tick;
  logic        req_ok;

  // idle snapshot: follow supply while stopped, fall back when too low
  assign snap_live = (target_q == 8'd0 && item_i.supply_mv > SUPPLY_VALID_MV)
                     ? item_i.supply_mv : snap_q;
  assign snap_tick = (snap_live < SUPPLY_VALID_MV)
                     ? ((item_i.idle_mv > SUPPLY_VALID_MV) ? item_i.idle_mv
                                                           : IDLE_DEFAULT_MV)
                     : snap_live;

  // undervoltage window
  assign uv_hit = (item_i.supply_mv < cfg_i.min_voltage_mv) &&
                  (item_i.supply_mv > UV_FLOOR_MV);

  // over-current up/down counter
  assign oc_hit   = item_i.current_ma > cfg_i.max_current_ma;
  assign cnt_tick = oc_hit ? ((cnt_q != OC_COUNT_MAX) ? cnt_q + 2'd1 : cnt_q)
                           : ((cnt_q != 2'd0) ? cnt_q - 2'd1 : cnt_q);
  assign oc_trip  = oc_hit && (cnt_tick >= OC_TRIP_COUNT);

  // sag compare: supply * 100 against snapshot * (100 - percent)
  assign sag_lhs = 23'(item_i.supply_mv) * 23'(SAG_PERCENT_MAX);
  assign sag_rhs = 23'(snap_tick) * 23'(SAG_PERCENT_MAX - cfg_i.sag_percent);
  assign sag_hit = sag_lhs < sag_rhs;
  assign ceil_tick = (target_q != 8'd0)
                     ? ((sag_hit && ceil_q != 8'd0) ? ceil_q - 8'd1 : ceil_q)
                     : CEIL_FULL;

  // ramp toward min(target, ceiling), never overshooting
  assign eff     = (target_q < ceil_tick) ? target_q : ceil_tick;
  assign goal    = {eff, 8'h00};
  assign rate_dn = {cfg_i.ramp_rate, 1'b0};
  assign gap_up  = goal - duty_q;
  assign gap_dn  = duty_q - goal;

  always_comb begin
    duty_tick = duty_q;
    if (duty_q < goal) begin
      if (gap_up <= 16'(cfg_i.ramp_rate)) begin
        duty_tick = goal;
      end else begin
        duty_tick = duty_q + 16'(cfg_i.ramp_rate);
      end
    end else if (duty_q > goal) begin
      if (gap_dn <= 16'(rate_dn)) begin
        duty_tick = goal;
      end else begin
        duty_tick = duty_q - 16'(rate_dn);
      end
    end
  end

  // a nonzero target request is refused while locked
  assign req_ok = !(lock_q && item_i.target_duty != 8'd0);

  // next state per function
  always_comb begin
    target_d = target_q;
    duty_d   = duty_q;
    ceil_d   = ceil_q;
    snap_d   = snap_q;
    cnt_d    = cnt_q;
    lock_d   = lock_q;
    fault_d  = fault_q;
    case (item_i.func)
      FUNC_TICK: begin
        if (lock_q) begin
          target_d = 8'd0;
          duty_d   = 16'd0;
          ceil_d   = CEIL_FULL;
        end else begin
          snap_d = snap_tick;
          if (uv_hit) begin
            lock_d   = 1'b1;
            fault_d  = FAULT_UV;
            target_d = 8'd0;
            duty_d   = 16'd0;
            ceil_d   = CEIL_FULL;
          end else begin
            cnt_d = cnt_tick;
            if (oc_trip) begin
              lock_d   = 1'b1;
              fault_d  = FAULT_OC;
              target_d = 8'd0;
              duty_d   = 16'd0;
              ceil_d   = CEIL_FULL;
            end else begin
              ceil_d = ceil_tick;
              duty_d = duty_tick;
            end
          end
        end
      end
      FUNC_SET_TARGET: begin
        if (req_ok) begin
          if (target_q == 8'd0 && item_i.target_duty != 8'd0) begin
            ceil_d = CEIL_FULL;
            snap_d = 16'd0;
          end
          target_d = item_i.target_duty;
        end
      end
      FUNC_CLEAR: begin
        lock_d  = 1'b0;
        fault_d = FAULT_NONE;
        cnt_d   = 2'd0;
      end
      default: begin
        target_d = 8'd0;
        duty_d   = 16'd0;
        ceil_d   = CEIL_FULL;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= 8'd0;
      duty_q   <= 16'd0;
      ceil_q   <= CEIL_FULL;
      snap_q   <= 16'd0;
      cnt_q    <= 2'd0;
      lock_q   <= 1'b0;
      fault_q  <= FAULT_NONE;
    end else if (fire_i) begin
      target_q <= target_d;
      duty_q   <= duty_d;
      ceil_q   <= ceil_d;
      snap_q   <= snap_d;
      cnt_q    <= cnt_d;
      lock_q   <= lock_d;
      fault_q  <= fault_d;
    end
  end

  // result shows the state after the request
  assign res_o.duty      = duty_d[15:8];
  assign res_o.locked    = lock_d;
  assign res_o.fault     = fault_d;
  assign res_o.sag_limit = ceil_d;

  // lockout and fault code move together
  a_lock_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_q == (fault_q != FAULT_NONE))
    else $error("lockout and fault code disagree");

  // the motor is never driven while locked
  a_lock_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_q |-> (duty_q == 16'd0 && target_q == 8'd0))
    else $error("duty or target nonzero during lockout");

  // emergency stop halts the motor
  a_estop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.func == FUNC_ESTOP) |=>
      (duty_q == 16'd0 && target_q == 8'd0 && ceil_q == CEIL_FULL))
    else $error("emergency stop did not halt the motor");

endmodule

@@ rtl/core/mss_out_reg.sv @@
// ----------------------------------------------------------------------------
// mss_out_reg
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module mss_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  mss_pkg::result_t  res_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mss_pkg::result_t  res_o
);
  import mss_pkg::*;

  logic    valid_q;
  logic    valid_d;
  result_t res_q;

  // empty, or drained this cycle
  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/core/motor_soft_start_with_protection.sv @@
// ----------------------------------------------------------------------------
// motor_soft_start_with_protection
// PWM duty controller with soft start, sag limiting and safety lockout.
// ----------------------------------------------------------------------------
// Each request carries a function code (tick, set target, clear lockout,
// emergency stop) and returns one result with the integer duty, lockout flag,
// fault code and sag ceiling as they stand after the request. A request is
// registered in the input register on accept, then applied to the controller
// state as its result is loaded into the result register, with a new request
// accepted every cycle unless the result register stalls. The rate is set by
// the read-modify-write of the controller state in the core; the only
// back-pressure is a stalled result register. Configuration must be written
// through a plain write port only while no request is in flight; the block
// does not enforce this. Ramp rate and sag percent are range-limited on write.
module motor_soft_start_with_protection (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] current_ma_i,
  input  logic [15:0] supply_mv_i,
  input  logic [15:0] idle_mv_i,
  input  logic [7:0]  target_duty_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  duty_o,
  output logic        locked_o,
  output logic [1:0]  fault_o,
  output logic [7:0]  sag_limit_o
);
  import mss_pkg::*;

  cfg_t    cfg;
  item_t   item_in;
  item_t   item_q;
  logic    item_valid;
  logic    out_ready;
  logic    fire;
  result_t res_core;
  result_t res_out;

  // pack request fields
  assign item_in.func        = func_e'(func_i);
  assign item_in.current_ma  = current_ma_i;
  assign item_in.supply_mv   = supply_mv_i;
  assign item_in.idle_mv     = idle_mv_i;
  assign item_in.target_duty = target_duty_i;

  // a registered request moves on when the result register has room
  assign fire = item_valid && out_ready;

  mss_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mss_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .take_i     (fire),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  mss_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_core)
  );

  mss_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_i       (res_core),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  // unpack result fields
  assign duty_o      = res_out.duty;
  assign locked_o    = res_out.locked;
  assign fault_o     = res_out.fault;
  assign sag_limit_o = res_out.sag_limit;

endmodule

@@ tb/sv/motor_soft_start_with_protection_tb.sv @@
// ----------------------------------------------------------------------------
// motor_soft_start_with_protection_tb
// Self-checking bench for the motor soft-start and protection controller.
// ----------------------------------------------------------------------------
// A mirror of the controller state is stepped for every accepted request and
// the duty/status it should show is queued. Each result leaving the block is
// compared field by field with the oldest queued status. Directed tests cover
// the ramp, sag ceiling, over-current and undervoltage lockout paths. Random
// traffic then runs plausible tick sequences under several register settings,
// with random idle bursts on both channels and a final back-to-back stretch.
module motor_soft_start_with_protection_tb;
  import mss_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TOTAL_REQUESTS = 1950;
  localparam int PHASE_REQUESTS = 240;
  localparam int MAX_PRINTED    = 100;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  // block ports
  logic        cfg_we      = 1'b0;
  logic [1:0]  cfg_idx     = CFG_MAX_CURRENT;
  logic [15:0] cfg_wdata   = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [1:0]  func        = FUNC_TICK;
  logic [15:0] current_ma  = '0;
  logic [15:0] supply_mv   = '0;
  logic [15:0] idle_mv     = '0;
  logic [7:0]  target_duty = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [7:0]  duty;
  logic        locked;
  logic [1:0]  fault;
  logic [7:0]  sag_limit;

  motor_soft_start_with_protection u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .func_i        (func),
    .current_ma_i  (current_ma),
    .supply_mv_i   (supply_mv),
    .idle_mv_i     (idle_mv),
    .target_duty_i (target_duty),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .duty_o        (duty),
    .locked_o      (locked),
    .fault_o       (fault),
    .sag_limit_o   (sag_limit)
  );

  // mirrored registers
  logic [15:0] c_max_cur = MAX_CURRENT_RST;
  logic [15:0] c_min_mv  = MIN_VOLTAGE_RST;
  logic [6:0]  c_sag     = SAG_PERCENT_RST;
  logic [12:0] c_ramp    = RAMP_RATE_RST;

  // mirrored controller state
  logic [7:0]  m_target = '0;
  int          m_duty   = 0;
  logic [7:0]  m_ceil   = CEIL_FULL;
  logic [15:0] m_snap   = '0;
  logic [1:0]  m_oc     = '0;
  logic        m_lock   = 1'b0;
  fault_e      m_fault  = FAULT_NONE;

  result_t expected_status[$];
  int      n_sent    = 0;
  int      n_checked = 0;
  int      n_errors  = 0;
  bit      quiet_tail = 1'b0;
  bit      in_idle_en = 1'b1;
  bit      stall_en   = 1'b1;
  int      stall_left = 0;

  // ---------------------------------------------------------------------------
  // controller mirror
  // ---------------------------------------------------------------------------

  function automatic void stop_drive();
    m_target = '0;
    m_duty   = 0;
    m_ceil   = CEIL_FULL;
  endfunction

  function automatic void advance_tick(logic [15:0] cur, logic [15:0] sup, logic [15:0] idle);
    int         pct;
    int         rate;
    int         goal;
    logic [7:0] eff;
    if (m_lock) begin
      stop_drive();
      return;
    end
    // idle snapshot, with fallback when no valid reading was taken
    if (m_target == 0 && sup > SUPPLY_VALID_MV) m_snap = sup;
    if (m_snap < SUPPLY_VALID_MV) m_snap = (idle > SUPPLY_VALID_MV) ? idle : IDLE_DEFAULT_MV;
    // undervoltage lockout
    if (sup < c_min_mv && sup > UV_FLOOR_MV) begin
      m_lock  = 1'b1;
      m_fault = FAULT_UV;
      stop_drive();
      return;
    end
    // over-current debounce
    if (cur > c_max_cur) begin
      if (m_oc < OC_COUNT_MAX) m_oc++;
      if (m_oc >= OC_TRIP_COUNT) begin
        m_lock  = 1'b1;
        m_fault = FAULT_OC;
        stop_drive();
        return;
      end
    end else if (m_oc != 0) begin
      m_oc--;
    end
    // sag ceiling
    if (m_target != 0) begin
      pct = (c_sag > SAG_PERCENT_MAX) ? int'(SAG_PERCENT_MAX) : int'(c_sag);
      if (int'(sup) * 100 < int'(m_snap) * (100 - pct)) begin
        if (m_ceil != 0) m_ceil--;
      end
    end else begin
      m_ceil = CEIL_FULL;
    end
    // ramp toward the goal, falling twice as fast
    eff  = (m_target < m_ceil) ? m_target : m_ceil;
    goal = int'(eff) << 8;
    rate = int'(c_ramp);
    if (rate < int'(RAMP_RATE_MIN)) rate = int'(RAMP_RATE_MIN);
    if (rate > int'(RAMP_RATE_MAX)) rate = int'(RAMP_RATE_MAX);
    if (m_duty < goal) begin
      m_duty += rate;
      if (m_duty > goal) m_duty = goal;
    end else if (m_duty > goal) begin
      m_duty -= 2 * rate;
      if (m_duty < goal) m_duty = goal;
    end
  endfunction

  function automatic result_t step_controller(func_e f, logic [15:0] cur, logic [15:0] sup,
                                              logic [15:0] idle, logic [7:0] req);
    result_t r;
    case (f)
      FUNC_TICK: begin
        advance_tick(cur, sup, idle);
      end
      FUNC_SET_TARGET: begin
        // nonzero targets are refused while locked out
        if (!(m_lock && req != 0)) begin
          if (m_target == 0 && req != 0) begin
            m_ceil = CEIL_FULL;
            m_snap = '0;
          end
          m_target = req;
        end
      end
      FUNC_CLEAR: begin
        m_lock  = 1'b0;
        m_fault = FAULT_NONE;
        m_oc    = '0;
      end
      default: begin
        stop_drive();
      end
    endcase
    r.duty      = 8'(m_duty >> 8);
    r.locked    = m_lock;
    r.fault     = m_fault;
    r.sag_limit = m_ceil;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  task automatic send_req(func_e f, logic [15:0] cur, logic [15:0] sup, logic [15:0] idle,
                          logic [7:0] req);
    int gap;
    if (!quiet_tail && in_idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    current_ma  <= cur;
    supply_mv   <= sup;
    idle_mv     <= idle;
    target_duty <= req;
    do @(posedge clk); while (in_stall);
    expected_status.push_back(step_controller(f, cur, sup, idle, req));
    n_sent++;
  endtask

  task automatic send_tick(logic [15:0] cur, logic [15:0] sup, logic [15:0] idle);
    send_req(FUNC_TICK, cur, sup, idle, 8'($urandom));
  endtask

  task automatic set_target(logic [7:0] req);
    send_req(FUNC_SET_TARGET, 16'($urandom), 16'($urandom), 16'($urandom), req);
  endtask

  task automatic clear_lockout();
    send_req(FUNC_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic emergency_stop();
    send_req(FUNC_ESTOP, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // tick with sensor readings around the present operating point
  task automatic send_plant_tick(bit sag_push);
    int          base;
    int          pct;
    int          lo;
    int          hi;
    int          pick;
    logic [15:0] cur;
    logic [15:0] sup;
    logic [15:0] idle;
    base = (m_snap < SUPPLY_VALID_MV) ? int'(IDLE_DEFAULT_MV) : int'(m_snap);
    pct  = (c_sag > SAG_PERCENT_MAX) ? int'(SAG_PERCENT_MAX) : int'(c_sag);
    if (sag_push) begin
      hi = base * (100 - pct) / 100 - 1;
      lo = hi - base / 20;
    end else begin
      lo = base * (95 - pct) / 100;
      hi = base + base / 20;
    end
    if (lo < 0) lo = 0;
    if (hi < lo) hi = lo;
    if (hi > 65535) hi = 65535;
    if (lo > hi) lo = hi;
    pick = $urandom_range(0, 99);
    if (sag_push || pick < 80) sup = 16'($urandom_range(hi, lo));
    else if (pick < 87) sup = 16'($urandom_range(UV_FLOOR_MV, 0));
    else if (pick < 93 && c_min_mv > UV_FLOOR_MV + 1)
      sup = 16'($urandom_range(c_min_mv - 1, UV_FLOOR_MV + 1));
    else sup = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (sag_push || pick < 82) cur = 16'($urandom_range(c_max_cur, 0));
    else if (pick < 95 && c_max_cur != 16'hFFFF)
      cur = 16'($urandom_range(16'hFFFF, c_max_cur + 1));
    else cur = 16'($urandom);
    idle = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(SUPPLY_VALID_MV, 0)) : 16'($urandom);
    send_tick(cur, sup, idle);
  endtask

  // random requests, or a run: clear if locked, set a target, tick with commands
  task automatic run_episode();
    int len;
    int pick;
    int i;
    bit sag_push;
    in_idle_en = ($urandom_range(0, 3) != 0);
    stall_en   = ($urandom_range(0, 3) != 0);
    pick = $urandom_range(0, 29);
    if (pick < 3) begin
      repeat ($urandom_range(1, 6))
        send_req(func_e'(2'($urandom)), 16'($urandom), 16'($urandom), 16'($urandom),
                 8'($urandom));
    end else begin
      sag_push = (pick == 3);
      if (m_lock) clear_lockout();
      set_target(8'($urandom_range(1, 255)));
      len = sag_push ? $urandom_range(260, 300) : $urandom_range(4, 50);
      for (i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        if (sag_push || pick < 92) send_plant_tick(sag_push);
        else if (pick < 96) set_target(8'($urandom_range(0, 255)));
        else if (pick < 98) emergency_stop();
        else clear_lockout();
      end
    end
  endtask

  // let every queued status come back before touching the registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_MAX_CURRENT: c_max_cur = data;
      CFG_MIN_VOLTAGE: c_min_mv  = data;
      CFG_SAG_PERCENT: c_sag     = data[6:0];
      default:         c_ramp    = data[12:0];
    endcase
  endtask

  task automatic program_config(logic [15:0] max_cur, logic [15:0] min_mv,
                                logic [15:0] sag_pct, logic [15:0] ramp);
    write_reg(CFG_SAG_PERCENT, sag_pct);
    write_reg(CFG_MAX_CURRENT, max_cur);
    write_reg(CFG_RAMP_RATE, ramp);
    write_reg(CFG_MIN_VOLTAGE, min_mv);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int got, int want);
    if (n_errors < MAX_PRINTED)
      $display("mismatch on %s at result %0d: got %0d, expected %0d", what, n_checked, got,
               want);
    n_errors++;
  endtask

  // random result stall bursts
  always @(posedge clk) begin
    if (quiet_tail || !stall_en) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each accepted result with the oldest queued status
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        report_mismatch("result with no request pending, duty", int'(duty), 0);
      end else begin
        want = expected_status.pop_front();
        if (duty !== want.duty) report_mismatch("duty", int'(duty), int'(want.duty));
        if (locked !== want.locked) report_mismatch("locked", int'(locked), int'(want.locked));
        if (fault !== want.fault) report_mismatch("fault", int'(fault), int'(want.fault));
        if (sag_limit !== want.sag_limit)
          report_mismatch("sag_limit", int'(sag_limit), int'(want.sag_limit));
        n_checked++;
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    int quiet_cycles;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // ramp up at the rate, down at twice the rate, clamped at the goal
  task automatic test_soft_start();
    send_tick(16'd0, 16'd12000, 16'd12000);
    set_target(8'd255);
    repeat (3) send_tick(16'd100, 16'd12000, 16'd0);
    set_target(8'd1);
    send_tick(16'd0, 16'd12000, 16'd0);
    set_target(8'd0);
    send_tick(16'd0, 16'd12000, 16'd0);
  endtask

  // snapshot fallback to idle reading and to the default, then ceiling steps down
  task automatic test_sag_limit();
    set_target(8'd200);
    send_tick(16'd0, 16'd9500, 16'd7000);
    emergency_stop();
    set_target(8'd200);
    send_tick(16'd0, 16'd9500, 16'd0);
    send_tick(16'd0, 16'd9500, 16'hFFFF);
    emergency_stop();
  endtask

  // three net over-current ticks trip the lockout
  task automatic test_over_current();
    set_target(8'd50);
    send_tick(16'd5001, 16'd12000, 16'd0);
    send_tick(16'd5001, 16'd12000, 16'd0);
    send_tick(16'd5000, 16'd12000, 16'd0);
    send_tick(16'hFFFF, 16'd12000, 16'd0);
    send_tick(16'hFFFF, 16'd12000, 16'd0);
    set_target(8'd100);
    set_target(8'd0);
    send_tick(16'd0, 16'd12000, 16'd0);
    clear_lockout();
  endtask

  // undervoltage window bounds and the lockout it causes
  task automatic test_undervoltage();
    send_tick(16'd0, UV_FLOOR_MV, 16'd0);
    send_tick(16'd0, 16'd0, 16'd0);
    send_tick(16'd0, 16'd8999, 16'd0);
    clear_lockout();
    send_tick(16'd0, 16'd9000, 16'd0);
    send_tick(16'd0, 16'hFFFF, 16'hFFFF);
  endtask

  // random traffic under a sequence of register settings
  task automatic test_random_configs();
    int p;
    int goal;
    goal = n_sent;
    for (p = 0; p < 7; p++) begin
      wait_idle();
      case (p)
        0: program_config(16'd0, 16'd0, 16'd0, 16'd0);
        1: program_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: program_config(MAX_CURRENT_RST, MIN_VOLTAGE_RST, 16'(SAG_PERCENT_RST),
                          16'(RAMP_RATE_RST));
        3: program_config(16'hFFFF, UV_FLOOR_MV + 16'd1, 16'(SAG_PERCENT_MAX),
                          16'(RAMP_RATE_MAX));
        4: program_config(16'd2000, 16'd6000, 16'(SAG_PERCENT_MAX) + 16'd1,
                          16'(RAMP_RATE_MIN) - 16'd1);
        5: program_config(16'($urandom), 16'($urandom_range(12000, 0)), 16'($urandom),
                          16'($urandom));
        default: program_config(16'($urandom_range(8000, 1000)), 16'($urandom_range(9000, 0)),
                                16'($urandom_range(100, 0)),
                                16'($urandom_range(RAMP_RATE_MAX, RAMP_RATE_MIN)));
      endcase
      goal += PHASE_REQUESTS;
      while (n_sent < goal) run_episode();
    end
  endtask

  // no idling on either side for the last stretch
  task automatic test_back_to_back();
    quiet_tail = 1'b1;
    while (n_sent < TOTAL_REQUESTS) run_episode();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_soft_start();
    test_sag_limit();
    test_over_current();
    test_undervoltage();
    test_random_configs();
    test_back_to_back();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
